FILE: sv/lrm_pkg.sv
package lrm_pkg;

    localparam int MaxPixelsDef = 65536;
    localparam int MaxDimDef    = 1024;
    localparam int MaxWindowDef = 9;

    localparam int CfgIdxW  = 2;
    localparam int CfgDataW = 11;

    // Configuration register indexes.
    localparam logic [CfgIdxW-1:0] CFG_WIDTH  = 2'd0;
    localparam logic [CfgIdxW-1:0] CFG_HEIGHT = 2'd1;
    localparam logic [CfgIdxW-1:0] CFG_WINDOW = 2'd2;

    // Command codes.
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Status codes.
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_COORD  = 2'd1;
    localparam logic [1:0] ST_SIZE   = 2'd2;

    typedef struct packed {
        logic       cmd;
        logic [9:0] pos_x;
        logic [9:0] pos_y;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [1:0] status;
    } t_out_item;

    // Classified item handed from the front part to the back part.
    typedef struct packed {
        logic        is_query;
        logic [1:0]  status;
        logic [19:0] addr;
        logic [23:0] pixel;
        logic [9:0]  start_x;
        logic [9:0]  start_y;
    } t_job;

    // Luma of one pixel: the sum of the channels divided by three.
    function automatic logic [7:0] luma_of(input logic [23:0] p);
        logic [9:0]  sum;
        logic [19:0] prod;
        begin
            sum  = 10'(p[23:16]) + 10'(p[15:8]) + 10'(p[7:0]);
            // Reciprocal multiply, exact for sums up to 765.
            prod = 20'(sum) * 20'd683;
            luma_of = prod[18:11];
        end
    endfunction

endpackage

FILE: sv/lrm_front.sv
module lrm_front
    import lrm_pkg::*;
#(
    parameter int MAX_PIXELS = MaxPixelsDef,
    parameter int MAX_DIM    = MaxDimDef,
    parameter int MAX_WINDOW = MaxWindowDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_take,
    input  t_in_item     i_item,
    input  logic [10:0]  i_width,
    input  logic [10:0]  i_height,
    input  logic [3:0]   i_window,
    output logic         o_valid,
    output t_job         o_job
);

    logic        r_valid;
    t_job        r_job;
    logic        frame_ok;
    logic        window_ok;
    logic [21:0] area;
    logic [2:0]  half;
    logic [10:0] sx_pre;
    logic [10:0] sy_pre;
    logic [10:0] sx;
    logic [10:0] sy;
    logic [20:0] addr;
    t_job        n_job;

    assign area = 22'(i_width) * 22'(i_height);
    assign frame_ok = (i_width >= 11'd1) && (32'(i_width) <= MAX_DIM)
                   && (i_height >= 11'd1) && (32'(i_height) <= MAX_DIM)
                   && (32'(area) <= MAX_PIXELS);
    assign window_ok = i_window[0] && (32'(i_window) <= MAX_WINDOW)
                    && (11'(i_window) <= i_width) && (11'(i_window) <= i_height);

    // Window start: half a window back, then pulled inside the frame.
    assign half   = i_window[3:1];
    assign sx_pre = (i_item.pos_x > 10'(half)) ? 11'(i_item.pos_x - 10'(half)) : 11'd0;
    assign sy_pre = (i_item.pos_y > 10'(half)) ? 11'(i_item.pos_y - 10'(half)) : 11'd0;
    assign sx = (sx_pre + 11'(i_window) > i_width)  ? i_width  - 11'(i_window) : sx_pre;
    assign sy = (sy_pre + 11'(i_window) > i_height) ? i_height - 11'(i_window) : sy_pre;
    assign addr = 21'(i_item.pos_y) * 21'(i_width) + 21'(i_item.pos_x);

    // Classify the item.
    always_comb begin
        n_job          = '0;
        n_job.is_query = (i_item.cmd == CMD_QUERY);
        n_job.pixel    = {i_item.in_red, i_item.in_green, i_item.in_blue};
        n_job.addr     = addr[19:0];
        n_job.start_x  = sx[9:0];
        n_job.start_y  = sy[9:0];
        if (!frame_ok || (n_job.is_query && !window_ok)) begin
            n_job.status = ST_SIZE;
        end else if (11'(i_item.pos_x) >= i_width || 11'(i_item.pos_y) >= i_height) begin
            n_job.status = ST_COORD;
        end else begin
            n_job.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_take;
        end
        if (i_take) begin
            r_job <= n_job;
        end
    end

    assign o_valid = r_valid;
    assign o_job   = r_job;

endmodule

FILE: sv/lrm_queue.sv
module lrm_queue
    import lrm_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_job  i_job,
    input  logic  i_pop,
    output logic  o_valid,
    output t_job  o_job
);

    // Two-entry queue between the front and back parts.
    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
        if (i_push) begin
            r_mem[r_wp] <= i_job;
        end
    end

    assign o_valid = (r_cnt != 2'd0);
    assign o_job   = r_mem[r_rp];

endmodule

FILE: sv/lrm_back.sv
module lrm_back
    import lrm_pkg::*;
#(
    parameter int MAX_PIXELS = MaxPixelsDef,
    parameter int MAX_WINDOW = MaxWindowDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_job        i_job,
    input  logic [10:0] i_width,
    input  logic [3:0]  i_window,
    output logic        o_pop,
    output logic        o_done,
    output t_out_item   o_result
);

    localparam int AddrW = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
    localparam int WinN  = MAX_WINDOW * MAX_WINDOW;
    localparam int IdxW  = $clog2(WinN + 1);
    localparam int WdW   = $clog2(MAX_WINDOW + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_READ, S_PASS, S_LI, S_CMP, S_NEXT, S_SEND
    } t_state;

    // Pixel store.
    logic [23:0] r_store [MAX_PIXELS];
    logic [23:0] r_rdata;

    t_state         r_state;
    t_job           r_job;
    logic [WdW-1:0] r_row;
    logic [WdW-1:0] r_col;
    logic [IdxW-1:0] r_n;
    logic [IdxW-1:0] r_i;
    logic [IdxW-1:0] r_j;
    logic [IdxW-1:0] r_cnt;
    logic           r_rd_pend;
    logic [23:0]    r_win [WinN];
    logic [23:0]    r_wq;
    logic [23:0]    r_pi;
    logic [23:0]    r_pick;
    logic [7:0]     r_li;
    logic           r_done;
    t_out_item      r_result;

    logic [20:0]    rd_addr;
    logic           rd_en;
    logic [IdxW-1:0] rd_idx;
    logic [7:0]     lj;
    logic [IdxW-1:0] wsz;
    logic [IdxW-1:0] nsq;

    assign wsz = IdxW'(i_window);
    assign nsq = IdxW'(wsz * wsz);
    assign rd_addr = 21'(r_job.start_y + 10'(r_row)) * 21'(i_width)
                   + 21'(r_job.start_x + 10'(r_col));
    assign rd_en = (r_state == S_READ) && (r_row < WdW'(i_window));
    assign lj = luma_of(r_wq);

    // Window buffer address: the candidate first, then the pixels it is
    // compared against, one ahead of the compare.
    always_comb begin
        case (r_state)
            S_PASS:  rd_idx = r_i;
            S_CMP:   rd_idx = (r_j == nsq - 1'b1) ? r_j : r_j + 1'b1;
            default: rd_idx = r_j;
        endcase
    end

    // Store write by a load; registered read for query windows.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_valid && !i_job.is_query && i_job.status == ST_OK
            && 32'(i_job.addr) < MAX_PIXELS) begin
            r_store[AddrW'(i_job.addr)] <= i_job.pixel;
        end
        if (rd_en) begin
            r_rdata <= r_store[AddrW'(rd_addr)];
        end
    end

    // Window buffer: filled while gathering, read one entry a cycle.
    always_ff @(posedge i_clk) begin
        if (r_state == S_READ && r_rd_pend) begin
            r_win[r_n] <= r_rdata;
        end
        r_wq <= r_win[rd_idx];
    end

    // Sequencer: gather a query window, rank pixels in turn to median.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_done    <= 1'b0;
            r_rd_pend <= 1'b0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_job    <= i_job;
                        r_row    <= '0;
                        r_col    <= '0;
                        r_n      <= '0;
                        r_rd_pend <= 1'b0;
                        r_pick   <= '0;
                        if (i_job.is_query && i_job.status == ST_OK) begin
                            r_state <= S_READ;
                        end else begin
                            r_state <= S_SEND;
                        end
                    end
                end
                S_READ: begin
                    r_rd_pend <= rd_en;
                    if (r_rd_pend) begin
                        r_n <= r_n + 1'b1;
                    end
                    if (rd_en) begin
                        if (r_col == WdW'(i_window) - 1'b1) begin
                            r_col <= '0;
                            r_row <= r_row + 1'b1;
                        end else begin
                            r_col <= r_col + 1'b1;
                        end
                    end else if (!r_rd_pend) begin
                        r_i     <= '0;
                        r_state <= S_PASS;
                    end
                end
                S_PASS: begin
                    r_j     <= '0;
                    r_cnt   <= '0;
                    r_state <= S_LI;
                end
                S_LI: begin
                    // The candidate pixel has arrived from the buffer.
                    r_li    <= luma_of(r_wq);
                    r_pi    <= r_wq;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (lj > r_li || (lj == r_li && r_j < r_i)) begin
                        r_cnt <= r_cnt + 1'b1;
                    end
                    if (r_j == nsq - 1'b1) begin
                        r_state <= S_NEXT;
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_NEXT: begin
                    if (r_cnt == (nsq >> 1)) begin
                        r_pick  <= r_pi;
                        r_state <= S_SEND;
                    end else if (r_i == nsq - 1'b1) begin
                        r_state <= S_SEND;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_PASS;
                    end
                end
                S_SEND: begin
                    r_done   <= 1'b1;
                    r_result <= '{out_red: r_pick[23:16], out_green: r_pick[15:8],
                                  out_blue: r_pick[7:0], status: r_job.status};
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_pop    = (r_state == S_IDLE) && i_valid;
    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

FILE: sv/luma_ranked_median_window_filter.sv
// Luma-ranked median window filter over a stored RGB frame.
// Input channel: an item is taken at a clock edge with i_start high and
// o_busy low. A load (cmd 0) writes one pixel at pos_y*width+pos_x; a query
// (cmd 1) returns the pixel of middle rank by descending luma in the square
// window around the position, clamped inside the frame.
// Output channel: each item yields one result shown for one cycle with
// o_done high; the receiver cannot hold it off.
// Configuration: i_cfg_we, i_cfg_idx, i_cfg_data write width, height and
// window size; write only while the block is idle.
// Flow: a load or an error goes through the front register, the queue and
// the back part's send state when the back part is free. A query reads its
// n = w*w window pixels through the single store read port, then ranks each
// candidate by one compare per cycle, stopping at the median.
// A two-entry queue lets the front take a new item while the back works;
// o_busy is high while two items wait in the front register and the queue.
// Reset clears control state and sets width 256, height 256, window 3; the
// pixel store is not cleared and must be written before it is read.
module luma_ranked_median_window_filter
    import lrm_pkg::*;
#(
    parameter int MAX_PIXELS = MaxPixelsDef,
    parameter int MAX_DIM    = MaxDimDef,
    parameter int MAX_WINDOW = MaxWindowDef
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    output logic                o_busy,
    input  t_in_item            i_item,
    output logic                o_done,
    output t_out_item           o_result,
    input  logic                i_cfg_we,
    input  logic [CfgIdxW-1:0]  i_cfg_idx,
    input  logic [CfgDataW-1:0] i_cfg_data
);

    logic [10:0] r_width;
    logic [10:0] r_height;
    logic [3:0]  r_window;
    logic        f_valid;
    t_job        f_job;
    logic        q_valid;
    t_job        q_job;
    logic        pop;
    logic [1:0]  r_inflight;
    logic        take;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 11'd256;
            r_height <= 11'd256;
            r_window <= 4'd3;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_WIDTH:  r_width  <= i_cfg_data;
                CFG_HEIGHT: r_height <= i_cfg_data;
                CFG_WINDOW: r_window <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // Count items in front stage plus queue so the queue never overflows.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= 2'd0;
        end else begin
            r_inflight <= r_inflight + 2'(take) - 2'(pop);
        end
    end

    assign o_busy = (r_inflight == 2'd2);
    assign take   = i_start && !o_busy;

    lrm_front #(.MAX_PIXELS(MAX_PIXELS), .MAX_DIM(MAX_DIM), .MAX_WINDOW(MAX_WINDOW)) u_front (
        .i_clk, .i_rst_n, .i_take(take), .i_item,
        .i_width(r_width), .i_height(r_height), .i_window(r_window),
        .o_valid(f_valid), .o_job(f_job)
    );

    lrm_queue u_queue (
        .i_clk, .i_rst_n, .i_push(f_valid), .i_job(f_job),
        .i_pop(pop), .o_valid(q_valid), .o_job(q_job)
    );

    lrm_back #(.MAX_PIXELS(MAX_PIXELS), .MAX_WINDOW(MAX_WINDOW)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .i_job(q_job),
        .i_width(r_width), .i_window(r_window),
        .o_pop(pop), .o_done, .o_result
    );

endmodule

FILE: sv/lrm_checker.sv
module lrm_checker
    import lrm_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_start,
    input logic      o_busy,
    input logic      o_done,
    input t_out_item o_result
);

    // Status only takes a defined code.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.status == ST_OK || o_result.status == ST_COORD
                    || o_result.status == ST_SIZE))
        else $error("unused status code");

    // Errors carry a zero pixel.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_OK) |->
        (o_result.out_red == 8'd0 && o_result.out_green == 8'd0
         && o_result.out_blue == 8'd0))
        else $error("error result with nonzero pixel");

    // A result strobe lasts one cycle.
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("done held two cycles");

    // No result right after reset without an item.
    a_no_early: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("result right after reset");

    // Busy only rises after an item was taken.
    a_busy_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_busy) |-> $past(i_start))
        else $error("busy rose without an item");

endmodule

bind luma_ranked_median_window_filter lrm_checker u_chk (
    .i_clk, .i_rst_n, .i_start, .o_busy, .o_done, .o_result
);
